@@ design/apis_pkg.sv @@
// Package for the alignment pairwise identity statistics block.
// Holds payload structs, lane/pair constants, the letter test and pair ordering.
// No dependencies.
package apis_pkg;

  localparam int unsigned Lanes = 8;
  localparam int unsigned Pairs = 28;
  localparam logic [16:0] CntMax = 17'h1ffff;
  localparam logic [19:0] LetterMax = 20'hfffff;
  localparam logic [20:0] OvlMax = 21'h1fffff;
  localparam logic [0:0] ModeColumn = 1'b0;
  localparam logic [0:0] ModeLength = 1'b1;

  typedef struct packed {
    logic [0:0]  mode;
    logic [7:0]  residue_0;
    logic [7:0]  residue_1;
    logic [7:0]  residue_2;
    logic [7:0]  residue_3;
    logic [7:0]  residue_4;
    logic [7:0]  residue_5;
    logic [7:0]  residue_6;
    logic [7:0]  residue_7;
    logic [2:0]  seq_index;
    logic [16:0] seq_length;
    logic [0:0]  last_column;
  } in_item_t;

  typedef struct packed {
    logic [16:0] mean_identity;
    logic [24:0] average_length;
    logic [16:0] aligned_coverage;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StPair, StMean, StAvg, StCov, StDone
  } fin_state_e;

  // Status from the finishing sequencer to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } fin_status_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  // Number of pairs among n sequences, n in 2..8.
  function automatic logic [4:0] pair_count(input logic [3:0] n);
    logic [5:0] nw;
    nw = {2'b00, n};
    return 5'((nw * (nw - 6'd1)) >> 1);
  endfunction

  // Sequences {i, j} of the k-th pair in row order among n sequences.
  function automatic logic [5:0] pair_sel(input logic [3:0] n, input logic [4:0] k);
    logic [5:0] r;
    int unsigned c;
    r = '0;
    for (int nn = 2; nn <= 8; nn++) begin
      c = 0;
      for (int i = 0; i < nn; i++) begin
        for (int j = i + 1; j < nn; j++) begin
          if ((n == 4'(nn)) && (k == 5'(c))) r = {3'(i), 3'(j)};
          c++;
        end
      end
    end
    return r;
  endfunction

endpackage

@@ design/apis_divider.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its ports.
module apis_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic [DenW:0]   trial;

  always_comb begin
    trial = {rem_q[DenW-1:0], num_q[NumW-1]};
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      num_d = num_i;
      rem_d = '0;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      // shift in next numerator bit, subtract where it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = run_q && (cnt_q == CntW'(1));
  assign quot_o = num_d;
endmodule

@@ design/apis_pair_lane.sv @@
// One pair lane: overlap and match counters for one sequence pair.
// Depends on apis_pkg.
module apis_pair_lane (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        col_i,
  input  logic        clear_i,
  input  logic        active_i,
  input  logic [7:0]  res_a_i,
  input  logic [7:0]  res_b_i,
  output logic        ovl_o,
  output logic [16:0] match_o,
  output logic [16:0] overlap_o
);
  logic [16:0] match_q, overlap_q;
  logic both;

  assign both  = active_i && apis_pkg::is_letter(res_a_i) && apis_pkg::is_letter(res_b_i);
  assign ovl_o = col_i && both;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q   <= '0;
      overlap_q <= '0;
    end else if (clear_i) begin
      match_q   <= '0;
      overlap_q <= '0;
    end else if (col_i && both) begin
      if (overlap_q != apis_pkg::CntMax) overlap_q <= overlap_q + 17'd1;
      if ((res_a_i == res_b_i) && (match_q != apis_pkg::CntMax)) match_q <= match_q + 17'd1;
    end
  end

  assign match_o   = match_q;
  assign overlap_o = overlap_q;
endmodule

@@ design/alignment_pairwise_identity_stats.sv @@
// Top level: alignment pairwise identity statistics.
// Depends on apis_pkg, apis_pair_lane, apis_divider.
//
//  channel  | signals                         | handshake
//  ---------+---------------------------------+---------------------------
//  item in  | start_i, in_item_i              | start_i && !busy_o
//  result   | result_valid_o, result_o        | one-cycle strobe, no stall
//  config   | APB psel/penable/pwrite/paddr   | pready always high
//
// A length load writes one length register; on an ordinary column the 28 pair
// lanes update in parallel. The last column starts the finishing sequence:
// one pair per step through a shared bit-serial divider, then the mean,
// average and coverage divides. busy_o is high meanwhile.
// Reset clears counters and sets num_sequences to 8; loaded lengths are
// undefined until written. The receiver cannot stall results.
module alignment_pairwise_identity_stats #(
  parameter int unsigned MAX_SEQS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  apis_pkg::in_item_t   in_item_i,
  output logic                 busy_o,
  output logic                 result_valid_o,
  output apis_pkg::out_item_t  result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  localparam int unsigned L = apis_pkg::Lanes;
  localparam int unsigned P = apis_pkg::Pairs;
  localparam logic [3:0] MaxN = (MAX_SEQS > L) ? 4'(L) : 4'(MAX_SEQS);

  logic [3:0] nseq_q;
  logic [3:0] n_eff;
  logic [4:0] n_pairs;
  logic [16:0] len_q [L];
  logic [7:0] res [L];
  logic accept, col, last, clear;
  logic [P-1:0] ovl;
  logic [16:0] match [P];
  logic [16:0] overlap [P];

  // APB: single register at address 0
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {28'd0, nseq_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nseq_q <= 4'd8;
    else if (psel && penable && pwrite && (paddr == 2'd0)) nseq_q <= pwdata[3:0];
  end

  assign n_eff = (nseq_q < 4'd2) ? 4'd2 : ((nseq_q > MaxN) ? MaxN : nseq_q);
  assign n_pairs = apis_pkg::pair_count(n_eff);

  assign res[0] = in_item_i.residue_0;
  assign res[1] = in_item_i.residue_1;
  assign res[2] = in_item_i.residue_2;
  assign res[3] = in_item_i.residue_3;
  assign res[4] = in_item_i.residue_4;
  assign res[5] = in_item_i.residue_5;
  assign res[6] = in_item_i.residue_6;
  assign res[7] = in_item_i.residue_7;

  assign accept = start_i && !busy_o;
  assign col    = accept && (in_item_i.mode == apis_pkg::ModeColumn);
  assign last   = col && in_item_i.last_column[0];

  // lengths: register file indexed by seq_index
  always_ff @(posedge clk_i) begin
    if (accept && (in_item_i.mode == apis_pkg::ModeLength))
      len_q[in_item_i.seq_index] <= in_item_i.seq_length;
  end

  // pair lanes: slot k counts the k-th pair (i,j), i<j, in row order for the current count
  for (genvar gk = 0; gk < P; gk++) begin : g_lane
    logic [5:0] sel;
    assign sel = apis_pkg::pair_sel(n_eff, 5'(gk));
    apis_pair_lane u_lane (
      .clk_i, .rst_ni, .col_i(col), .clear_i(clear),
      .active_i(5'(gk) < n_pairs),
      .res_a_i(res[sel[5:3]]), .res_b_i(res[sel[2:0]]),
      .ovl_o(ovl[gk]), .match_o(match[gk]), .overlap_o(overlap[gk])
    );
  end

  // merging: letter and overlap totals
  logic [19:0] letter_q;
  logic [20:0] ovl_tot_q;
  logic [3:0]  let_cnt;
  logic [5:0]  ovl_cnt;
  logic [20:0] let_sum;
  logic [21:0] ovl_sum;
  always_comb begin
    let_cnt = '0;
    for (int i = 0; i < L; i++)
      if ((4'(i) < n_eff) && apis_pkg::is_letter(res[i])) let_cnt = let_cnt + 4'd1;
    ovl_cnt = 6'($countones(ovl));
    let_sum = {1'b0, letter_q} + 21'(let_cnt);
    ovl_sum = {1'b0, ovl_tot_q} + 22'(ovl_cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q  <= '0;
      ovl_tot_q <= '0;
    end else if (clear) begin
      letter_q  <= '0;
      ovl_tot_q <= '0;
    end else if (col) begin
      letter_q  <= (let_sum > 21'(apis_pkg::LetterMax)) ? apis_pkg::LetterMax : let_sum[19:0];
      ovl_tot_q <= (ovl_sum > 22'(apis_pkg::OvlMax)) ? apis_pkg::OvlMax : ovl_sum[20:0];
    end
  end

  // finishing sequencer; totals include the last column; sequence and pair counts snapshot into hold regs
  apis_pkg::fin_state_e st_q, st_d;
  apis_pkg::fin_status_t fin;
  logic [4:0]  k_q, k_d;
  logic [3:0]  nf_q;
  logic [4:0]  npairs_q;
  logic [23:0] id_sum_q, id_sum_d;
  logic [21:0] min_sum_q, min_sum_d;
  logic [16:0] mean_q, mean_d;
  logic [24:0] avg_q, avg_d;
  logic [16:0] cov_q, cov_d;
  logic        div_start, div_done, div_wait_q, div_wait_d;
  logic [47:0] div_num, div_quot;
  logic [39:0] div_den;
  logic        res_v_q, res_v_d;

  logic [16:0] m_k, o_k, la, lb;
  logic [5:0]  fin_sel;
  assign fin_sel = apis_pkg::pair_sel(nf_q, k_q);
  assign m_k = match[k_q];
  assign o_k = overlap[k_q];
  assign la  = len_q[fin_sel[5:3]];
  assign lb  = len_q[fin_sel[2:0]];

  always_comb begin
    st_d = st_q; k_d = k_q; id_sum_d = id_sum_q; min_sum_d = min_sum_q;
    mean_d = mean_q; avg_d = avg_q; cov_d = cov_q;
    div_start = 1'b0; div_num = '0; div_den = '0; div_wait_d = div_wait_q;
    res_v_d = 1'b0; clear = 1'b0;
    fin.busy = (st_q != apis_pkg::StIdle);
    fin.done = 1'b0;
    unique case (st_q)
      apis_pkg::StIdle: begin
        if (last) begin
          st_d = apis_pkg::StPair; k_d = '0; id_sum_d = '0; min_sum_d = '0;
          div_wait_d = 1'b0;
        end
      end
      apis_pkg::StPair: begin
        if (k_q >= npairs_q) begin
          st_d = apis_pkg::StMean; div_wait_d = 1'b0;
        end else if (!div_wait_q) begin
          min_sum_d = min_sum_q + 22'((la < lb) ? la : lb);
          if (o_k != 17'd0) begin
            div_start = 1'b1; div_wait_d = 1'b1;
            div_num = 48'({m_k, 17'd0}) + 48'(o_k);
            div_den = 40'({o_k, 1'b0});
          end else k_d = k_q + 5'd1;
        end else if (div_done) begin
          id_sum_d = id_sum_q + 24'(div_quot); div_wait_d = 1'b0;
          k_d = k_q + 5'd1;
        end
      end
      apis_pkg::StMean: begin
        if (!div_wait_q) begin
          div_start = 1'b1; div_wait_d = 1'b1;
          div_num = 48'({id_sum_q, 1'b0}) + 48'(npairs_q);
          div_den = 40'({npairs_q, 1'b0});
        end else if (div_done) begin
          mean_d = (div_quot > 48'd65536) ? 17'd65536 : div_quot[16:0];
          div_wait_d = 1'b0; st_d = apis_pkg::StAvg;
        end
      end
      apis_pkg::StAvg: begin
        if (!div_wait_q) begin
          div_start = 1'b1; div_wait_d = 1'b1;
          div_num = 48'({letter_q, 9'd0}) + 48'(nf_q);
          div_den = 40'({nf_q, 1'b0});
        end else if (div_done) begin
          avg_d = (div_quot > 48'h1ffffff) ? 25'h1ffffff : div_quot[24:0];
          div_wait_d = 1'b0; st_d = apis_pkg::StCov;
        end
      end
      apis_pkg::StCov: begin
        if (min_sum_q == 22'd0) begin
          cov_d = '0; st_d = apis_pkg::StDone;
        end else if (!div_wait_q) begin
          div_start = 1'b1; div_wait_d = 1'b1;
          div_num = 48'({ovl_tot_q, 17'd0}) + 48'(min_sum_q);
          div_den = 40'({min_sum_q, 1'b0});
        end else if (div_done) begin
          cov_d = (div_quot > 48'h1ffff) ? 17'h1ffff : div_quot[16:0];
          div_wait_d = 1'b0; st_d = apis_pkg::StDone;
        end
      end
      apis_pkg::StDone: begin
        res_v_d = 1'b1; clear = 1'b1; fin.done = 1'b1; st_d = apis_pkg::StIdle;
      end
      default: st_d = apis_pkg::StIdle;
    endcase
  end

  apis_divider #(.NumW(48), .DenW(40)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= apis_pkg::StIdle;
      div_wait_q <= 1'b0;
      res_v_q <= 1'b0;
      k_q <= '0;
    end else begin
      st_q <= st_d;
      div_wait_q <= div_wait_d;
      res_v_q <= res_v_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_sum_q <= id_sum_d;
    min_sum_q <= min_sum_d;
    mean_q <= mean_d;
    avg_q <= avg_d;
    cov_q <= cov_d;
    if (last) begin
      nf_q <= n_eff;
      npairs_q <= n_pairs;
    end
  end

  assign busy_o = fin.busy;
  assign result_valid_o = res_v_q;
  assign result_o.mean_identity = mean_q;
  assign result_o.average_length = avg_q;
  assign result_o.aligned_coverage = cov_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !col) else $error("column taken while finishing");
  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.done |=> result_valid_o) else $error("result strobe missing");
  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == apis_pkg::StPair) |-> (k_q <= npairs_q)) else $error("pair index past end");
endmodule
